@@ design/kmm_pkg.sv @@
// Shared constants and types for the k-mer minimizer block.
package kmm_pkg;

  localparam int unsigned HASH_W     = 64;
  localparam int unsigned BASE_W     = 2;
  localparam int unsigned OUT_POS_W  = 32;
  localparam int unsigned KMER_MAX   = 32;
  localparam int unsigned LEN_W      = 6;
  localparam int unsigned FILL_W     = 7;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [HASH_W-1:0] HASH_SEED = 64'h8F3F73B5CF1C9ADE;
  localparam logic [FILL_W-1:0] FILL_CAP  = 7'd127;

  localparam logic [LEN_W-1:0] KMER_LEN_RST = 6'd12;
  localparam logic [LEN_W-1:0] WIN_LEN_RST  = 6'd20;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] CFG_KMER_LEN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_LEN  = 1'b1;

  localparam int unsigned MAX_WINDOW_KMERS_DEF = 32;
  localparam int unsigned POSITION_BITS_DEF    = 32;

  // per-cell control from the sequencer
  typedef struct packed {
    logic shift;   // take the neighbor's hash
    logic in_win;  // cell lies inside the current window
  } cell_ctl_t;

endpackage

@@ design/kmm_cell.sv @@
// One hash cell: holds a k-mer hash and folds it into the passing min token.
module kmm_cell #(
  parameter int unsigned IDX_W    = 5,
  parameter int unsigned CELL_IDX = 0
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  kmm_pkg::cell_ctl_t           ctl_i,
  input  logic [kmm_pkg::HASH_W-1:0]   hash_i,
  output logic [kmm_pkg::HASH_W-1:0]   hash_o,
  input  logic                         tok_vld_i,
  input  logic                         tok_has_i,
  input  logic [kmm_pkg::HASH_W-1:0]   tok_min_i,
  input  logic [IDX_W-1:0]             tok_at_i,
  output logic                         tok_vld_o,
  output logic                         tok_has_o,
  output logic [kmm_pkg::HASH_W-1:0]   tok_min_o,
  output logic [IDX_W-1:0]             tok_at_o
);

  logic [kmm_pkg::HASH_W-1:0] hash_q;
  logic                       tok_vld_q;
  logic                       tok_has_q;
  logic [kmm_pkg::HASH_W-1:0] tok_min_q;
  logic [IDX_W-1:0]           tok_at_q;
  logic                       take;

  // strict compare: on a tie the older (upstream) entry wins
  assign take = ctl_i.in_win && (!tok_has_i || (hash_q < tok_min_i));

  always_ff @(posedge clk_i) begin
    if (ctl_i.shift) begin
      hash_q <= hash_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_vld_q <= 1'b0;
    end else begin
      tok_vld_q <= tok_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_vld_i) begin
      tok_has_q <= tok_has_i || take;
      tok_min_q <= take ? hash_q : tok_min_i;
      tok_at_q  <= take ? IDX_W'(CELL_IDX) : tok_at_i;
    end
  end

  assign hash_o    = hash_q;
  assign tok_vld_o = tok_vld_q;
  assign tok_has_o = tok_has_q;
  assign tok_min_o = tok_min_q;
  assign tok_at_o  = tok_at_q;

endmodule

@@ design/sliding_window_kmer_minimizer_top.sv @@
// Top level of the sliding-window k-mer minimizer: sequencer, cell row, result stage.
//
// Usage: bases enter on the in channel (in_valid_i / in_ready_o), one 2-bit base per
// beat with first/last-of-sequence flags. Minimizers leave on the out channel
// (out_valid_o / out_ready_i), at most one beat per base. Two 6-bit registers
// (k-mer length at index 0, window length at index 1) are written on the cfg
// channel, which is always ready; write them only while the block is idle.
// Each hash is shifted into a row of MAX_WINDOW_KMERS cells, newest in cell 0.
// A window evaluation sends a min token from the far end of the row to cell 0,
// one cell per cycle, each cell in the window folding in its own hash.
// A base that closes no window leaves the block ready for the next base; a base
// that closes a window holds the in channel off (in_ready_o low) until its result
// leaves the hold stage, set by the token walk down the cell row. The result is
// then registered in the out register.
// A finished result sits in a hold stage if the out register is still full, so
// a stalled receiver holds the block off only while both are occupied.
// Reset: k-mer length 12, window length 20, sequence state cleared, no
// output pending. Cell contents are not reset and are never read before written.
module sliding_window_kmer_minimizer_top #(
  parameter int unsigned MAX_WINDOW_KMERS = kmm_pkg::MAX_WINDOW_KMERS_DEF,
  parameter int unsigned POSITION_BITS    = kmm_pkg::POSITION_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // config channel
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [kmm_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [kmm_pkg::LEN_W-1:0]        cfg_data_i,
  // base channel
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [kmm_pkg::BASE_W-1:0]       base_i,
  input  logic                             first_of_sequence_i,
  input  logic                             last_of_sequence_i,
  // minimizer channel
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [kmm_pkg::HASH_W-1:0]       minimizer_hash_o,
  output logic [kmm_pkg::OUT_POS_W-1:0]    minimizer_position_o
);

  localparam int unsigned IDX_W = (MAX_WINDOW_KMERS > 1) ? $clog2(MAX_WINDOW_KMERS) : 1;
  localparam int unsigned NW    = $clog2(MAX_WINDOW_KMERS + 1);
  localparam int unsigned HW    = kmm_pkg::HASH_W;

  // ---------------- configuration registers ----------------
  logic [kmm_pkg::LEN_W-1:0] kmer_len_q;
  logic [kmm_pkg::LEN_W-1:0] win_len_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kmer_len_q <= kmm_pkg::KMER_LEN_RST;
      win_len_q  <= kmm_pkg::WIN_LEN_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        kmm_pkg::CFG_KMER_LEN: kmer_len_q <= cfg_data_i;
        kmm_pkg::CFG_WIN_LEN:  win_len_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------- sequence state ----------------
  logic [HW-1:0]                 kmer_q, kmer_base, kmer_d, kmask;
  logic [POSITION_BITS-1:0]      bases_q, bases_base, bases_d;
  logic [kmm_pkg::FILL_W-1:0]    fill_q, fill_base, fill_d;
  logic                          emitted_q;
  logic [POSITION_BITS-1:0]      last_pos_q;
  logic                          busy_q;
  logic                          tok_start_q;

  // item context held across the scan
  logic [NW-1:0]                 n_q;
  logic [POSITION_BITS-1:0]      newest_q;
  logic                          last_q;

  logic                          in_acc;
  logic [kmm_pkg::LEN_W-1:0]     k_act;
  logic [7:0]                    k8, w8, span, held, n_d, maxw8;
  logic                          has_kmer;
  logic                          scan_need;
  logic [HW-1:0]                 new_hash;

  assign in_ready_o = !busy_q;
  assign in_acc     = in_valid_i && in_ready_o;

  // k clamps to 1..32
  always_comb begin
    k_act = kmer_len_q;
    if (kmer_len_q == '0) begin
      k_act = kmm_pkg::LEN_W'(1);
    end else if (kmer_len_q > kmm_pkg::LEN_W'(kmm_pkg::KMER_MAX)) begin
      k_act = kmm_pkg::LEN_W'(kmm_pkg::KMER_MAX);
    end
  end

  always_comb begin
    for (int j = 0; j < kmm_pkg::KMER_MAX; j++) begin
      kmask[2*j +: 2] = (kmm_pkg::LEN_W'(j) < k_act) ? 2'b11 : 2'b00;
    end
  end

  assign kmer_base  = first_of_sequence_i ? '0 : kmer_q;
  assign bases_base = first_of_sequence_i ? '0 : bases_q;
  assign fill_base  = first_of_sequence_i ? '0 : fill_q;

  assign kmer_d   = {kmer_base[HW-3:0], base_i} & kmask;
  assign bases_d  = bases_base + POSITION_BITS'(1);
  assign fill_d   = (fill_base == kmm_pkg::FILL_CAP) ? fill_base
                                                     : fill_base + kmm_pkg::FILL_W'(1);
  assign new_hash = kmer_d ^ kmm_pkg::HASH_SEED;

  assign k8       = {2'b00, k_act};
  assign w8       = {2'b00, win_len_q};
  assign maxw8    = 8'(MAX_WINDOW_KMERS);
  assign has_kmer = ({1'b0, fill_d} >= k8);
  assign held     = {1'b0, fill_d} - k8 + 8'd1;

  // k-mers per window, capped by the cell row
  always_comb begin
    if (w8 < k8) begin
      span = 8'd1;
    end else begin
      span = w8 - k8 + 8'd1;
    end
    if (span > maxw8) begin
      span = maxw8;
    end
  end

  // full window, or what exists at the last base of a short sequence
  always_comb begin
    priority if (held >= span) begin
      n_d = span;
    end else if (last_of_sequence_i) begin
      n_d = held;
    end else begin
      n_d = 8'd0;
    end
  end

  assign scan_need = has_kmer && (n_d != 8'd0);

  // ---------------- cell row ----------------
  kmm_pkg::cell_ctl_t        ctl     [MAX_WINDOW_KMERS];
  logic [HW-1:0]             hash_w  [MAX_WINDOW_KMERS];
  logic [MAX_WINDOW_KMERS-1:0] tok_vld_w;
  logic                      tok_has_w [MAX_WINDOW_KMERS];
  logic [HW-1:0]             tok_min_w [MAX_WINDOW_KMERS];
  logic [IDX_W-1:0]          tok_at_w  [MAX_WINDOW_KMERS];

  for (genvar g = 0; g < MAX_WINDOW_KMERS; g++) begin : g_cell
    logic          vld_in, has_in;
    logic [HW-1:0] min_in, hash_in;
    logic [IDX_W-1:0] at_in;

    assign ctl[g].shift  = in_acc && has_kmer;
    assign ctl[g].in_win = (NW'(g) < n_q);

    if (g == 0) begin : g_head
      assign hash_in = new_hash;
    end else begin : g_body
      assign hash_in = hash_w[g-1];
    end

    // token enters at the oldest end of the row
    if (g == MAX_WINDOW_KMERS - 1) begin : g_tail
      assign vld_in = tok_start_q;
      assign has_in = 1'b0;
      assign min_in = '0;
      assign at_in  = '0;
    end else begin : g_link
      assign vld_in = tok_vld_w[g+1];
      assign has_in = tok_has_w[g+1];
      assign min_in = tok_min_w[g+1];
      assign at_in  = tok_at_w[g+1];
    end

    kmm_cell #(
      .IDX_W    (IDX_W),
      .CELL_IDX (g)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (ctl[g]),
      .hash_i    (hash_in),
      .hash_o    (hash_w[g]),
      .tok_vld_i (vld_in),
      .tok_has_i (has_in),
      .tok_min_i (min_in),
      .tok_at_i  (at_in),
      .tok_vld_o (tok_vld_w[g]),
      .tok_has_o (tok_has_w[g]),
      .tok_min_o (tok_min_w[g]),
      .tok_at_o  (tok_at_w[g])
    );
  end

  // ---------------- result hold and output register ----------------
  logic                     fin_vld_q;
  logic [HW-1:0]            fin_min_q;
  logic [IDX_W-1:0]         fin_at_q;
  logic                     fin_take;
  logic [POSITION_BITS-1:0] cand_pos;
  logic                     emit;
  logic                     out_valid_q;
  logic [HW-1:0]            out_hash_q;
  logic [POSITION_BITS-1:0] out_pos_q;

  // cell index counts back from the newest k-mer
  assign cand_pos = newest_q - POSITION_BITS'(fin_at_q);
  assign emit     = !emitted_q || (cand_pos != last_pos_q);
  assign fin_take = fin_vld_q && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i) begin
    if (tok_vld_w[0]) begin
      fin_min_q <= tok_min_w[0];
      fin_at_q  <= tok_at_w[0];
    end
    if (in_acc) begin
      n_q      <= NW'(n_d);
      newest_q <= bases_d - POSITION_BITS'(k_act);
      last_q   <= last_of_sequence_i;
    end
    if (fin_take && emit) begin
      out_hash_q <= fin_min_q;
      out_pos_q  <= cand_pos;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kmer_q      <= '0;
      bases_q     <= '0;
      fill_q      <= '0;
      emitted_q   <= 1'b0;
      last_pos_q  <= '0;
      busy_q      <= 1'b0;
      tok_start_q <= 1'b0;
      fin_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      tok_start_q <= in_acc && scan_need;

      if (tok_vld_w[0]) begin
        fin_vld_q <= 1'b1;
      end else if (fin_take) begin
        fin_vld_q <= 1'b0;
      end

      if (fin_take && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      if (in_acc) begin
        // last base clears the running state for the next sequence
        kmer_q  <= last_of_sequence_i ? '0 : kmer_d;
        bases_q <= last_of_sequence_i ? '0 : bases_d;
        fill_q  <= last_of_sequence_i ? '0 : fill_d;
        busy_q  <= scan_need;
        if (first_of_sequence_i || (last_of_sequence_i && !scan_need)) begin
          emitted_q  <= 1'b0;
          last_pos_q <= '0;
        end
      end else if (fin_take) begin
        busy_q <= 1'b0;
        if (last_q) begin
          emitted_q  <= 1'b0;
          last_pos_q <= '0;
        end else if (emit) begin
          emitted_q  <= 1'b1;
          last_pos_q <= cand_pos;
        end
      end
    end
  end

  assign out_valid_o          = out_valid_q;
  assign minimizer_hash_o     = out_hash_q;
  assign minimizer_position_o = kmm_pkg::OUT_POS_W'(out_pos_q);

`ifndef SYNTHESIS
  // at most one min token or held result exists at a time
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({tok_vld_w, fin_vld_q, tok_start_q}))
    else $error("more than one window scan in flight");

  // scan activity only while the block holds off new bases
  a_scan_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tok_start_q || fin_vld_q || (|tok_vld_w)) |-> busy_q)
    else $error("scan active while idle");

  // handing a result on frees the block
  a_fin_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_take |=> (!busy_q && !fin_vld_q))
    else $error("block stays busy after result handoff");

  // a fresh base never arrives with a scan token already on the row
  a_acc_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> (!(|tok_vld_w) && !fin_vld_q))
    else $error("base accepted during scan");
`endif

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the sliding-window k-mer minimizer.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned RING_DEPTH    = kmm_pkg::MAX_WINDOW_KMERS_DEF;
  // margin for a window evaluation to finish, result or not
  localparam int unsigned SETTLE_CYCLES = 2 * (RING_DEPTH + 3) + 8;
  localparam int unsigned ITEM_TARGET   = 1700;
  localparam int unsigned CYCLE_LIMIT   = 2_000_000;

  typedef struct packed {
    logic [kmm_pkg::HASH_W-1:0]    hash;
    logic [kmm_pkg::OUT_POS_W-1:0] pos;
  } minimizer_t;

  // Predicts minimizers from the accepted base stream and checks them in order.
  class minimizer_board;
    logic [kmm_pkg::LEN_W-1:0]     kmer_len_reg;
    logic [kmm_pkg::LEN_W-1:0]     win_len_reg;
    logic [kmm_pkg::HASH_W-1:0]    kmer_val;
    logic [kmm_pkg::HASH_W-1:0]    hash_ring [RING_DEPTH];
    logic [kmm_pkg::OUT_POS_W-1:0] base_count;
    logic [kmm_pkg::OUT_POS_W-1:0] last_pos;
    logic                          emitted;
    int unsigned                   fill;
    int unsigned                   head;
    minimizer_t                    pending_minimizers[$];
    int unsigned                   errors;

    function new();
      kmer_len_reg = kmm_pkg::KMER_LEN_RST;
      win_len_reg  = kmm_pkg::WIN_LEN_RST;
      errors       = 0;
      clear_seq();
    endfunction

    function void clear_seq();
      kmer_val   = '0;
      base_count = '0;
      last_pos   = '0;
      emitted    = 1'b0;
      fill       = 0;
      head       = 0;
    endfunction

    function void set_reg(logic [kmm_pkg::CFG_IDX_W-1:0] idx,
                          logic [kmm_pkg::LEN_W-1:0] data);
      if (idx == kmm_pkg::CFG_KMER_LEN) kmer_len_reg = data;
      else win_len_reg = data;
    endfunction

    // k-mer length the block actually uses: 0 acts as 1, above 32 acts as 32
    function int unsigned active_kmer();
      if (kmer_len_reg < 1) return 1;
      if (kmer_len_reg > kmm_pkg::KMER_MAX) return kmm_pkg::KMER_MAX;
      return kmer_len_reg;
    endfunction

    function void note_base(logic [kmm_pkg::BASE_W-1:0] nt, logic first, logic last);
      int unsigned k, span, held, n, at, slot, i;
      logic [kmm_pkg::HASH_W-1:0]    kmask, best, v;
      logic [kmm_pkg::OUT_POS_W-1:0] newest, pos;
      minimizer_t                    m;
      if (first) clear_seq();
      k = active_kmer();
      kmask = (k >= kmm_pkg::KMER_MAX) ? '1 : ((64'd1 << (2 * k)) - 64'd1);
      kmer_val = ((kmer_val << 2) | nt) & kmask;
      base_count = base_count + 1;
      if (fill < kmm_pkg::FILL_CAP) fill++;
      n = 0;
      if (fill >= k) begin
        hash_ring[head] = kmer_val ^ kmm_pkg::HASH_SEED;
        head = (head + 1) % RING_DEPTH;
        held = fill - k + 1;
        span = (win_len_reg < k) ? 1 : win_len_reg - k + 1;
        if (span > RING_DEPTH) span = RING_DEPTH;
        if (held >= span) n = span;
        else if (last) n = held;
        if (n > 0) begin
          // leftmost smallest among the newest n hashes
          slot = (head + RING_DEPTH - n) % RING_DEPTH;
          best = hash_ring[slot];
          at = 0;
          for (i = 1; i < n; i++) begin
            v = hash_ring[(slot + i) % RING_DEPTH];
            if (v < best) begin
              best = v;
              at = i;
            end
          end
          newest = base_count - k;
          pos = newest - (n - 1) + at;
          if (!emitted || pos != last_pos) begin
            emitted  = 1'b1;
            last_pos = pos;
            m.hash   = best;
            m.pos    = pos;
            pending_minimizers.insert(pending_minimizers.size(), m);
          end
        end
      end
      if (last) clear_seq();
    endfunction

    function void check_minimizer(logic [kmm_pkg::HASH_W-1:0] hash,
                                  logic [kmm_pkg::OUT_POS_W-1:0] pos);
      minimizer_t m;
      if (pending_minimizers.size() == 0) begin
        $display("%0t: unexpected minimizer, expected none, got hash %h pos %0d",
                 $time, hash, pos);
        errors++;
        return;
      end
      m = pending_minimizers[0];
      pending_minimizers.delete(0);
      if (hash !== m.hash) begin
        $display("%0t: minimizer hash mismatch, expected %h, got %h", $time, m.hash, hash);
        errors++;
      end
      if (pos !== m.pos) begin
        $display("%0t: minimizer position mismatch, expected %0d, got %0d",
                 $time, m.pos, pos);
        errors++;
      end
    endfunction

    function bit idle();
      return pending_minimizers.size() == 0;
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [kmm_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [kmm_pkg::LEN_W-1:0]     cfg_data;
  logic                          in_valid;
  logic                          in_ready;
  logic [kmm_pkg::BASE_W-1:0]    nt_drv;
  logic                          first_drv;
  logic                          last_drv;
  logic                          out_valid;
  logic                          out_ready;
  logic [kmm_pkg::HASH_W-1:0]    min_hash;
  logic [kmm_pkg::OUT_POS_W-1:0] min_pos;

  minimizer_board board = new();

  int unsigned items_sent = 0;
  int unsigned burst_left = 0;
  int unsigned cycle_count = 0;
  bit          seq_open = 1'b0;

  // receiver stall state
  int unsigned seg_left = 0;
  int unsigned seg_mode = 0;
  logic [31:0] stall_pat = 32'h1;

  sliding_window_kmer_minimizer_top u_top (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_valid_i          (cfg_valid),
    .cfg_ready_o          (cfg_ready),
    .cfg_index_i          (cfg_index),
    .cfg_data_i           (cfg_data),
    .in_valid_i           (in_valid),
    .in_ready_o           (in_ready),
    .base_i               (nt_drv),
    .first_of_sequence_i  (first_drv),
    .last_of_sequence_i   (last_drv),
    .out_valid_o          (out_valid),
    .out_ready_i          (out_ready),
    .minimizer_hash_o     (min_hash),
    .minimizer_position_o (min_pos)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake or a lost minimizer ends here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d minimizers still expected", $time,
               board.pending_minimizers.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Output beats are sampled at the edge, before the block's own updates land.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) board.check_minimizer(min_hash, min_pos);
  end

  // Receiver: segments of always-ready, a rotating stall pattern, or random stalls.
  always @(posedge clk_i) begin
    if (seg_left == 0) begin
      seg_left  = $urandom_range(16, 400);
      seg_mode  = $urandom_range(0, 3);
      stall_pat = $urandom | 32'h1;  // never all-stall
    end
    seg_left--;
    case (seg_mode)
      0: out_ready <= 1'b1;
      1: begin
        out_ready <= stall_pat[0];
        stall_pat = {stall_pat[0], stall_pat[31:1]};
      end
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= 1'($urandom_range(0, 1));
    endcase
  end

  // One base beat. The sender runs in bursts; a gap drops valid before the
  // next burst starts, so valid is never lowered and raised in one step.
  task automatic send_base(input logic [kmm_pkg::BASE_W-1:0] nt, input logic f,
                           input logic l);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      case ($urandom_range(0, 5))
        0, 1: gap = 0;
        5: gap = $urandom_range(13, 50);
        default: gap = $urandom_range(1, 12);
      endcase
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid  <= 1'b1;
    nt_drv    <= nt;
    first_drv <= f;
    last_drv  <= l;
    do @(posedge clk_i); while (!in_ready);
    board.note_base(nt, f, l);
    items_sent++;
  endtask

  // Config beat; valid stays up so back-to-back writes need no re-raise.
  task automatic cfg_beat(input logic [kmm_pkg::CFG_IDX_W-1:0] idx,
                          input logic [kmm_pkg::LEN_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    board.set_reg(idx, data);
  endtask

  task automatic set_lengths(input logic [kmm_pkg::LEN_W-1:0] k,
                             input logic [kmm_pkg::LEN_W-1:0] w);
    cfg_beat(kmm_pkg::CFG_KMER_LEN, k);
    cfg_beat(kmm_pkg::CFG_WIN_LEN, w);
    cfg_valid <= 1'b0;
  endtask

  // Wait until every predicted minimizer is out, then let a silent window
  // evaluation finish before anything touches the registers.
  task automatic drain();
    in_valid <= 1'b0;
    while (!board.idle()) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // style: 0 random bases, 1 one repeated base (all-tie hashes), 2 two-base period.
  // noisy adds stray first/last flags inside the sequence.
  task automatic send_sequence(input int unsigned len, input int unsigned style,
                               input bit with_first, input bit with_last, input bit noisy);
    int unsigned                i;
    logic [kmm_pkg::BASE_W-1:0] nt, fixed_nt, alt_nt;
    logic                       f, l;
    fixed_nt = kmm_pkg::BASE_W'($urandom);
    alt_nt   = kmm_pkg::BASE_W'($urandom);
    for (i = 0; i < len; i++) begin
      case (style)
        0: nt = kmm_pkg::BASE_W'($urandom);
        1: nt = fixed_nt;
        default: nt = i[0] ? alt_nt : fixed_nt;
      endcase
      f = (i == 0) && with_first;
      l = (i == len - 1) && with_last;
      if (noisy) begin
        if ($urandom_range(0, 19) == 0) f = 1'b1;
        if ($urandom_range(0, 19) == 0) l = 1'b1;
      end
      send_base(nt, f, l);
    end
  endtask

  initial begin
    int unsigned               i, s, nseq, kk, len, style;
    logic [kmm_pkg::LEN_W-1:0] k, w;
    bit                        wf, wl;
    rst_ni    = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = kmm_pkg::CFG_KMER_LEN;
    cfg_data  = '0;
    in_valid  = 1'b0;
    nt_drv    = '0;
    first_drv = 1'b0;
    last_drv  = 1'b0;
    out_ready = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed part, reset lengths (k 12, window 20) ---
    // sequence shorter than one k-mer: no minimizer
    for (i = 0; i < 5; i++) send_base(i[1:0] ^ {i[2], 1'b0}, i == 0, i == 4);
    // short sequence, never a full window: minimum at the last base; all-T
    // gives equal hashes, so the leftmost one wins
    for (i = 0; i < 14; i++) send_base(2'd3, i == 0, i == 13);
    drain();
    // one-base k-mers, each its own window; every base code
    set_lengths(6'd1, 6'd1);
    for (i = 0; i < 4; i++) send_base(i[1:0], i == 0, i == 3);
    drain();
    // zero lengths: k acts as 1, window below k
    set_lengths(6'd0, 6'd0);
    send_base(2'd0, 1'b1, 1'b0);
    send_base(2'd3, 1'b0, 1'b1);

    // --- random phases ---
    while (items_sent < ITEM_TARGET) begin
      drain();
      if (seq_open) begin
        // sequence continues across the write: k may only grow here, so every
        // window slot read is one written in this sequence
        k = kmm_pkg::LEN_W'($urandom_range(board.active_kmer(), 63));
      end else begin
        case ($urandom_range(0, 7))
          0: k = 6'd0;
          1: k = 6'd1;
          2: k = 6'd32;
          3: k = 6'd63;
          4: k = kmm_pkg::LEN_W'($urandom_range(33, 62));
          default: k = kmm_pkg::LEN_W'($urandom_range(2, 31));
        endcase
      end
      kk = (k < 1) ? 1 : (k > kmm_pkg::KMER_MAX) ? kmm_pkg::KMER_MAX : k;
      case ($urandom_range(0, 6))
        0: w = 6'd0;
        1: w = 6'd63;
        2: w = kmm_pkg::LEN_W'($urandom_range(0, 63));
        default: w = kmm_pkg::LEN_W'(kk + $urandom_range(0, 12));
      endcase
      set_lengths(k, w);
      nseq = $urandom_range(2, 6);
      for (s = 0; s < nseq; s++) begin
        style = $urandom_range(0, 5);
        style = (style < 4) ? 0 : style - 3;
        case ($urandom_range(0, 5))
          0: len = $urandom_range(1, kk);
          1: len = $urandom_range(kk, kk + w);
          2: len = $urandom_range(120, 150);  // may run past the saturating fill count
          default: len = $urandom_range(kk + w, kk + w + 40);
        endcase
        // an open sequence from the last phase is continued, not restarted
        wf = (s == 0 && seq_open) ? 1'b0 : ($urandom_range(0, 5) != 0);
        wl = (s == nseq - 1) ? ($urandom_range(0, 3) != 0) : 1'b1;
        send_sequence(len, style, wf, wl, $urandom_range(0, 7) == 0);
        seq_open = !wl;
      end
    end

    drain();
    if (board.errors == 0 && board.idle()) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
